[rtl/core/sha256_byte_stream_hasher_macros.svh]
// assertion macros for the byte stream hasher
`ifndef SHA256_BYTE_STREAM_HASHER_MACROS_SVH
`define SHA256_BYTE_STREAM_HASHER_MACROS_SVH

// property that holds at every edge outside reset
`define SHA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`endif

[rtl/core/sha_pkg.sv]
// ----------------------------------------------------------------------------
// sha_pkg
// types, constants and round functions of the byte stream hasher
// ----------------------------------------------------------------------------
package sha_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last_byte;
  } in_req_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PLACE,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_EMIT
  } state_e;

  localparam logic [31:0] InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

[rtl/core/sha256_byte_stream_hasher.sv]
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher
// byte-serial sha-256 with padding and eight-word digest output
// ----------------------------------------------------------------------------
// channel  dir  handshake                 payload
// in       in   in_valid_i/in_ready_o     sha_pkg::in_req_t  (byte, has, last)
// out      out  out_valid_o/out_ready_i   sha_pkg::out_req_t (word, index, last)
//
// a byte that does not fill a chunk is accepted in ST_IDLE, then placed in ST_PLACE
// a chunk-filling byte adds the rounds of the shared round unit plus an add
// a final request adds up to two padded chunks and the eight digest words,
// one word per cycle while out_ready_i is high
// stalls on the output just hold the current word; input is not ready meanwhile
// reset returns hash state to the initial values, length and position to zero
module sha256_byte_stream_hasher (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sha_pkg::in_req_t   in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sha_pkg::out_req_t  out_req_o
);

  sha_pkg::state_e state_q, state_d;

  logic [31:0] chunk_q [16];
  logic [31:0] win_q   [16];
  logic [31:0] var_q   [8];
  logic [31:0] hash_q  [8];
  logic [63:0] len_q;
  logic [5:0]  pos_q;
  logic [5:0]  rnd_q;
  logic [2:0]  widx_q;
  logic [7:0]  byte_q;     // byte to place
  logic        has_q;      // a byte is pending placement
  logic        last_q;     // message ends after this request
  logic        padded_q;   // 0x80 marker placed
  logic        final_q;    // chunk in flight is the last one

  // current write position
  logic [3:0]  wsel;
  logic [1:0]  bsel;
  assign wsel = pos_q[5:2];
  assign bsel = pos_q[1:0];

  // shared round unit: schedule word and one compression round
  logic [31:0] w_cur, t1, t2;
  logic [3:0]  r0, r2, r7, r15;
  assign r0  = rnd_q[3:0];
  assign r2  = r0 - 4'd2;
  assign r7  = r0 - 4'd7;
  assign r15 = r0 - 4'd15;

  always_comb begin
    if (rnd_q < 6'd16) begin
      w_cur = chunk_q[r0];
    end else begin
      w_cur = sha_pkg::ssig1(win_q[r2]) + win_q[r7] + sha_pkg::ssig0(win_q[r15]) + win_q[r0];
    end
    t1 = var_q[7] + sha_pkg::bsig1(var_q[4])
       + ((var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6])) + sha_pkg::RoundK[rnd_q] + w_cur;
    t2 = sha_pkg::bsig0(var_q[0])
       + ((var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]));
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sha_pkg::ST_IDLE: if (in_valid_i) state_d = sha_pkg::ST_PLACE;
      sha_pkg::ST_PLACE: begin
        if (has_q) begin
          if (pos_q == 6'd63) state_d = sha_pkg::ST_ROUND;
          else if (!last_q)   state_d = sha_pkg::ST_IDLE;
        end else if (!last_q) begin
          state_d = sha_pkg::ST_IDLE;
        end else begin
          state_d = sha_pkg::ST_PAD;
        end
      end
      sha_pkg::ST_PAD: begin
        // marker, then zeros up to the length field or the chunk end
        if (padded_q && pos_q == 6'd56) state_d = sha_pkg::ST_ROUND;
        else if (pos_q == 6'd63)        state_d = sha_pkg::ST_ROUND;
      end
      sha_pkg::ST_ROUND: if (rnd_q == 6'd63) state_d = sha_pkg::ST_ADD;
      sha_pkg::ST_ADD: begin
        if (final_q)      state_d = sha_pkg::ST_EMIT;
        else if (last_q)  state_d = sha_pkg::ST_PAD;
        else              state_d = sha_pkg::ST_IDLE;
      end
      sha_pkg::ST_EMIT: if (out_ready_i && widx_q == 3'd7) state_d = sha_pkg::ST_IDLE;
      default: state_d = sha_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o  = (state_q == sha_pkg::ST_IDLE);
    out_valid_o = (state_q == sha_pkg::ST_EMIT);
    out_req_o.digest_word = hash_q[widx_q];
    out_req_o.word_index  = widx_q;
    out_req_o.last_word   = (widx_q == 3'd7);
  end

  // byte placement into chunk words, big-endian
  // the length cycle writes words 14 and 15 instead of a byte
  logic       put_en;
  logic [7:0] put_val;
  always_comb begin
    put_en  = 1'b0;
    put_val = byte_q;
    if (state_q == sha_pkg::ST_PLACE && has_q) put_en = 1'b1;
    if (state_q == sha_pkg::ST_PAD && !(padded_q && pos_q == 6'd56)) begin
      put_en  = 1'b1;
      put_val = padded_q ? 8'h00 : 8'h80;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sha_pkg::ST_IDLE;
      len_q    <= '0;
      pos_q    <= '0;
      rnd_q    <= '0;
      widx_q   <= '0;
      has_q    <= 1'b0;
      last_q   <= 1'b0;
      padded_q <= 1'b0;
      final_q  <= 1'b0;
      for (int i = 0; i < 8; i++) hash_q[i] <= sha_pkg::InitH[i];
    end else begin
      state_q <= state_d;
      case (state_q)
        sha_pkg::ST_IDLE: begin
          if (in_valid_i) begin
            byte_q <= in_req_i.data_byte;
            has_q  <= in_req_i.has_byte;
            last_q <= in_req_i.last_byte;
            if (in_req_i.has_byte) len_q <= len_q + 64'd8;
          end
        end
        sha_pkg::ST_PLACE, sha_pkg::ST_PAD: begin
          if (put_en) begin
            case (bsel)
              2'd0:    chunk_q[wsel] <= {put_val, 24'h0};
              2'd1:    chunk_q[wsel][23:16] <= put_val;
              2'd2:    chunk_q[wsel][15:8]  <= put_val;
              default: chunk_q[wsel][7:0]   <= put_val;
            endcase
            pos_q <= pos_q + 6'd1;
            if (state_q == sha_pkg::ST_PAD) padded_q <= 1'b1;
            if (state_q == sha_pkg::ST_PLACE) has_q <= 1'b0;
          end
          if (state_q == sha_pkg::ST_PAD && padded_q && pos_q == 6'd56) begin
            chunk_q[14] <= len_q[63:32];
            chunk_q[15] <= len_q[31:0];
            pos_q   <= '0;
            final_q <= 1'b1;
          end
          if (state_d == sha_pkg::ST_ROUND) begin
            for (int i = 0; i < 8; i++) var_q[i] <= hash_q[i];
          end
        end
        sha_pkg::ST_ROUND: begin
          win_q[r0] <= w_cur;
          var_q[7] <= var_q[6];
          var_q[6] <= var_q[5];
          var_q[5] <= var_q[4];
          var_q[4] <= var_q[3] + t1;
          var_q[3] <= var_q[2];
          var_q[2] <= var_q[1];
          var_q[1] <= var_q[0];
          var_q[0] <= t1 + t2;
          rnd_q <= rnd_q + 6'd1;
        end
        sha_pkg::ST_ADD: begin
          for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + var_q[i];
        end
        sha_pkg::ST_EMIT: begin
          if (out_ready_i) begin
            widx_q <= widx_q + 3'd1;
            if (widx_q == 3'd7) begin
              for (int i = 0; i < 8; i++) hash_q[i] <= sha_pkg::InitH[i];
              len_q    <= '0;
              pos_q    <= '0;
              last_q   <= 1'b0;
              padded_q <= 1'b0;
              final_q  <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[rtl/core/sha_checker.sv]
// ----------------------------------------------------------------------------
// sha_checker
// port-level checks of the byte stream hasher
// ----------------------------------------------------------------------------
`include "sha256_byte_stream_hasher_macros.svh"

module sha_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input sha_pkg::out_req_t out_req_o
);

  // never both ready for input and offering output
  `SHA_ASSERT(a_excl, !(in_ready_o && out_valid_o), "ready while emitting")
  // word index steps by one after each taken word but the last
  `SHA_ASSERT(a_step, (out_valid_o && out_ready_i && !out_req_o.last_word) |=> (out_valid_o && out_req_o.word_index == $past(out_req_o.word_index) + 3'd1), "digest index skipped")
  // last flag only on word seven
  `SHA_ASSERT(a_last, out_valid_o |-> (out_req_o.last_word == (out_req_o.word_index == 3'd7)), "bad last flag")
  // a stalled output holds
  `SHA_ASSERT(a_hold, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_req_o)), "output changed")

endmodule

bind sha256_byte_stream_hasher sha_checker u_sha_checker (.*);

[tb/sha256_byte_stream_hasher_test.sv]
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_test
// drives byte requests with random gaps, predicts sha-256 digests and checks
// every digest word request against a queue of expected words
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  sha_pkg::in_req_t   in_req_i;
  logic               out_valid_o;
  logic               out_ready_i;
  sha_pkg::out_req_t  out_req_o;

  sha256_byte_stream_hasher u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_req_o  (out_req_o)
  );

  // round constants of the standard, kept locally for the predictor
  localparam logic [31:0] KTab [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };
  localparam logic [31:0] HInit [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // predictor state: chunk being filled, running hash, length, position
  logic [7:0]  chunk_bytes [64];
  logic [31:0] run_hash [8];
  logic [63:0] msg_bits;
  int unsigned fill_pos;

  sha_pkg::out_req_t digest_q [$];
  int       fail_count;
  bit       no_idle;
  bit       hold_out;

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic hash_reset();
    for (int i = 0; i < 8; i++) run_hash[i] = HInit[i];
    msg_bits = '0;
    fill_pos = 0;
  endtask

  task automatic compress();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int t = 0; t < 16; t++)
      w[t] = {chunk_bytes[4*t], chunk_bytes[4*t+1], chunk_bytes[4*t+2], chunk_bytes[4*t+3]};
    for (int t = 16; t < 64; t++)
      w[t] = (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
           + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
    {a, b, c, d, e, f, g, h} = {run_hash[0], run_hash[1], run_hash[2], run_hash[3],
                                run_hash[4], run_hash[5], run_hash[6], run_hash[7]};
    for (int t = 0; t < 64; t++) begin
      t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g)) + KTab[t] + w[t];
      t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    run_hash[0] += a; run_hash[1] += b; run_hash[2] += c; run_hash[3] += d;
    run_hash[4] += e; run_hash[5] += f; run_hash[6] += g; run_hash[7] += h;
  endtask

  task automatic place_byte(logic [7:0] b);
    chunk_bytes[fill_pos] = b;
    fill_pos = (fill_pos + 1) % 64;
    if (fill_pos == 0) compress();
  endtask

  // predicts one accepted request, queueing eight digest words on a final one
  task automatic predict_digest(sha_pkg::in_req_t r);
    sha_pkg::out_req_t o;
    if (r.has_byte) begin
      place_byte(r.data_byte);
      msg_bits += 64'd8;
    end
    if (r.last_byte) begin
      place_byte(8'h80);
      while (fill_pos != 56) place_byte(8'h00);
      for (int i = 0; i < 8; i++) chunk_bytes[56+i] = msg_bits[63-8*i -: 8];
      fill_pos = 0;
      compress();
      for (int i = 0; i < 8; i++) begin
        o.digest_word = run_hash[i];
        o.word_index  = 3'(i);
        o.last_word   = (i == 7);
        digest_q.push_back(o);
      end
      hash_reset();
    end
  endtask

  // clock, 20 ns period
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // directed table; known digests of the empty message and of "abc"
  typedef struct {
    sha_pkg::in_req_t req;
    bit               known;
    logic [31:0]      word0;
  } dir_row_t;
  dir_row_t dir_rows [$];

  task automatic add_row(logic [7:0] b, bit hb, bit lb, bit kn, logic [31:0] w0);
    dir_row_t r;
    r.req = '{data_byte: b, has_byte: hb, last_byte: lb};
    r.known = kn;
    r.word0 = w0;
    dir_rows.push_back(r);
  endtask

  // sends one request, with a random gap before it unless idling is off
  task automatic send_req(sha_pkg::in_req_t r);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      in_req_i   <= '{data_byte: 8'($urandom), has_byte: 1'($urandom), last_byte: 1'b0};
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_digest(r);
  endtask

  // random message of n bytes, with byte-less strays if asked, ended by a final request that may carry a byte
  task automatic send_message(int n, bit stray);
    sha_pkg::in_req_t r;
    for (int i = 0; i < n; i++) begin
      r = '{data_byte: 8'($urandom), has_byte: 1'b1, last_byte: 1'b0};
      send_req(r);
      if (stray && $urandom_range(0, 7) == 0)
        send_req('{data_byte: 8'($urandom), has_byte: 1'b0, last_byte: 1'b0});
    end
    r = '{data_byte: 8'($urandom), has_byte: 1'($urandom), last_byte: 1'b1};
    send_req(r);
  endtask

  // receiver: random stalls, checking each accepted digest word request
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected digest word, expected none, actual %h idx %0d last %0b",
                 $realtime, out_req_o.digest_word, out_req_o.word_index, out_req_o.last_word);
        fail_count++;
      end else begin
        sha_pkg::out_req_t exp_w;
        exp_w = digest_q.pop_front();
        if (out_req_o.digest_word !== exp_w.digest_word) begin
          $display("%0t: digest_word expected %h actual %h", $realtime,
                   exp_w.digest_word, out_req_o.digest_word);
          fail_count++;
        end
        if (out_req_o.word_index !== exp_w.word_index) begin
          $display("%0t: word_index expected %0d actual %0d", $realtime,
                   exp_w.word_index, out_req_o.word_index);
          fail_count++;
        end
        if (out_req_o.last_word !== exp_w.last_word) begin
          $display("%0t: last_word expected %0b actual %0b", $realtime,
                   exp_w.last_word, out_req_o.last_word);
          fail_count++;
        end
      end
    end
  end

  // ready pattern: random stalls, a long hold on request, no random stalls once idling is off
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_out) begin
        out_ready_i <= 1'b0;
        repeat (600) @(posedge clk_i);
        hold_out = 1'b0;
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // watchdog
  initial begin
    #40ms;
    $display("sha256_byte_stream_hasher_test failed");
    $finish;
  end

  initial begin
    int k;
    fail_count = 0;
    no_idle    = 1'b0;
    hold_out   = 1'b0;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_req_i   = '0;
    hash_reset();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty final request, then "abc", then idle item and extremes
    add_row(8'h00, 1'b0, 1'b1, 1'b1, 32'he3b0c442);
    add_row(8'h61, 1'b1, 1'b0, 1'b0, '0);
    add_row(8'h62, 1'b1, 1'b0, 1'b0, '0);
    add_row(8'h63, 1'b1, 1'b1, 1'b1, 32'hba7816bf);
    add_row(8'hff, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b1, 1'b0, 1'b0, '0);
    add_row(8'hff, 1'b1, 1'b1, 1'b0, '0);
    add_row(8'hff, 1'b0, 1'b1, 1'b0, '0);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].known && dir_rows[i].req.last_byte) begin
        send_req(dir_rows[i].req);
        // the typed-in word must agree with the predictor too
        if (digest_q[digest_q.size() - 8].digest_word !== dir_rows[i].word0) begin
          $display("%0t: known digest expected %h actual %h", $realtime,
                   dir_rows[i].word0, digest_q[digest_q.size() - 8].digest_word);
          fail_count++;
        end
      end else begin
        send_req(dir_rows[i].req);
      end
    end
    // padding overflow at 56 bytes
    send_message(56, 1'b0);

    // long output hold while more messages are offered
    hold_out = 1'b1;
    send_message(2, 1'b0);
    send_message(1, 1'b0);
    send_message(3, 1'b0);

    // random messages, mostly short, sometimes across a chunk boundary
    k = 0;
    while (k < 40) begin
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(52, 66) : $urandom_range(0, 12);
      if (k > 30) no_idle = 1'b1;
      send_message(n, 1'b1);
      k += n + 1;
    end
    no_idle = 1'b1;
    in_valid_i <= 1'b0;

    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("sha256_byte_stream_hasher_test passed");
    end else begin
      $display("sha256_byte_stream_hasher_test failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/sha_pkg.sv
rtl/core/sha256_byte_stream_hasher.sv
rtl/core/sha_checker.sv
tb/sha256_byte_stream_hasher_test.sv
